// ===== hw/rtl/pclt_pkg.sv =====
package pclt_pkg;

	localparam int unsigned DATA_WIDTH_DEF = 32;
	localparam int unsigned FRAC_BITS_DEF  = 16;

	// Cycles from an accepted item to its result strobe.
	function automatic int unsigned pclt_latency(input int unsigned dw, input int unsigned fb);
		return 3 + (dw + 1) + 1 + (dw + 2 + fb) + 1;
	endfunction

endpackage

// ===== hw/rtl/pclt_sqrt.sv =====
module pclt_sqrt #(
	parameter int unsigned N  = 33,
	parameter int unsigned SW = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [2*N-1:0]  rad,
	input  logic [SW-1:0]   side,
	output logic            out_valid,
	output logic [N-1:0]    root,
	output logic [SW-1:0]   side_out
);
	// One result bit is settled in each stage, from the top pair of the radicand down.
	logic [2*N-1:0] rad_st  [0:N];
	logic [N+1:0]   rem_st  [0:N];
	logic [N-1:0]   res_st  [0:N];
	logic [SW-1:0]  side_st [0:N];
	logic           vld_st  [0:N];

	assign rad_st[0]  = rad;
	assign rem_st[0]  = '0;
	assign res_st[0]  = '0;
	assign side_st[0] = side;
	assign vld_st[0]  = in_valid;

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [N+3:0] tmp;
		logic [N+3:0] trial;
		logic         take;

		always_comb begin
			tmp   = {rem_st[k], rad_st[k][2*N-1 -: 2]};
			trial = {2'b00, res_st[k], 2'b01};
			take  = (tmp >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_st[k+1] <= 1'b0;
			end else begin
				vld_st[k+1] <= vld_st[k];
			end
		end

		always_ff @(posedge clk) begin
			rad_st[k+1]  <= {rad_st[k][2*N-3:0], 2'b00};
			rem_st[k+1]  <= take ? (N+2)'(tmp - trial) : tmp[N+1:0];
			res_st[k+1]  <= {res_st[k][N-2:0], take};
			side_st[k+1] <= side_st[k];
		end
	end

	assign out_valid = vld_st[N];
	assign root      = res_st[N];
	assign side_out  = side_st[N];

endmodule

// ===== hw/rtl/pclt_div.sv =====
module pclt_div #(
	parameter int unsigned NW = 50,
	parameter int unsigned DW = 32,
	parameter int unsigned SW = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side,
	output logic          out_valid,
	output logic [NW-1:0] quo,
	output logic [SW-1:0] side_out
);
	// Restoring division, one quotient bit per stage.
	logic [NW-1:0] num_st  [0:NW];
	logic [DW-1:0] den_st  [0:NW];
	logic [DW-1:0] rem_st  [0:NW];
	logic [NW-1:0] quo_st  [0:NW];
	logic [SW-1:0] side_st [0:NW];
	logic          vld_st  [0:NW];

	assign num_st[0]  = num;
	assign den_st[0]  = den;
	assign rem_st[0]  = '0;
	assign quo_st[0]  = '0;
	assign side_st[0] = side;
	assign vld_st[0]  = in_valid;

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [DW:0] tmp;
		logic        take;

		always_comb begin
			tmp  = {rem_st[k], num_st[k][NW-1]};
			take = (tmp >= {1'b0, den_st[k]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_st[k+1] <= 1'b0;
			end else begin
				vld_st[k+1] <= vld_st[k];
			end
		end

		always_ff @(posedge clk) begin
			num_st[k+1]  <= num_st[k] << 1;
			den_st[k+1]  <= den_st[k];
			rem_st[k+1]  <= take ? DW'(tmp - {1'b0, den_st[k]}) : tmp[DW-1:0];
			quo_st[k+1]  <= {quo_st[k][NW-2:0], take};
			side_st[k+1] <= side_st[k];
		end
	end

	assign out_valid = vld_st[NW];
	assign quo       = quo_st[NW];
	assign side_out  = side_st[NW];

endmodule

// ===== hw/rtl/parabola_line_crossing_time.sv =====
// Crossing time of a constant-acceleration trajectory with an axis-aligned line.
// An item is taken at each rising edge with start high; busy is always low, so
// a new item may be offered in every cycle. Each item gives start position,
// speed and acceleration on both axes, the line and the root to report.
// The block solves 0.5*a*t^2 + v*t + p0 = L on the chosen axis in fixed point.
// Exactly one result follows each item, marked by strobe for one cycle, with
// hit and hit_time; results come out in input order.
// Each item passes stage 1, stage 2, stage 3, the square-root pipeline (one
// result bit per stage), a numerator register, the divider pipeline (one
// quotient bit per stage) and the output register; the default is Q16.16.
// Throughput is one item per cycle.
// Zero acceleration or a negative discriminant gives hit low and time zero.
// Reset clears every valid bit, so nothing comes out until items are given.
// The receiver has no way to stall; a result must be taken in its cycle.
module parabola_line_crossing_time #(
	parameter int unsigned DATA_WIDTH = pclt_pkg::DATA_WIDTH_DEF,
	parameter int unsigned FRAC_BITS  = pclt_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [DATA_WIDTH-1:0] start_x,
	input  logic signed [DATA_WIDTH-1:0] start_y,
	input  logic signed [DATA_WIDTH-1:0] speed_x,
	input  logic signed [DATA_WIDTH-1:0] speed_y,
	input  logic signed [DATA_WIDTH-1:0] accel_x,
	input  logic signed [DATA_WIDTH-1:0] accel_y,
	input  logic                         line_is_vertical,
	input  logic signed [DATA_WIDTH-1:0] line_offset,
	input  logic                         want_second,
	output logic                         strobe,
	output logic                         hit,
	output logic signed [DATA_WIDTH-1:0] hit_time
);
	import pclt_pkg::*;

	localparam int unsigned W  = DATA_WIDTH;
	localparam int unsigned N  = W + 1;
	localparam int unsigned NW = W + 2 + FRAC_BITS;
	localparam int unsigned SW = 2 * W + 3;

	assign busy = 1'b0;

	// Stage 1: pick the axis, form d = L - p0 and the magnitudes.
	logic signed [W-1:0] p0_c, v_c, a_c;
	logic signed [W:0]   d_c;
	logic [W-1:0]        vmag_c, amag_c;
	logic [W:0]          dmag_c;

	always_comb begin
		p0_c   = line_is_vertical ? start_x : start_y;
		v_c    = line_is_vertical ? speed_x : speed_y;
		a_c    = line_is_vertical ? accel_x : accel_y;
		d_c    = {line_offset[W-1], line_offset} - {p0_c[W-1], p0_c};
		vmag_c = v_c[W-1] ? (~v_c + 1'b1) : v_c;
		amag_c = a_c[W-1] ? (~a_c + 1'b1) : a_c;
		dmag_c = d_c[W] ? (~d_c + 1'b1) : d_c;
	end

	logic                v_s1;
	logic [W-1:0]        vmag_s1, amag_s1;
	logic [W:0]          dmag_s1;
	logic signed [W-1:0] vel_s1;
	logic                aneg_s1, anz_s1, sub_s1, second_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		vmag_s1   <= vmag_c;
		amag_s1   <= amag_c;
		dmag_s1   <= dmag_c;
		vel_s1    <= v_c;
		aneg_s1   <= a_c[W-1];
		anz_s1    <= (a_c != '0);
		sub_s1    <= (a_c[W-1] != d_c[W]) && (d_c != '0);
		second_s1 <= want_second;
	end

	// Stage 2: the two products v^2 and |a|*|d|.
	logic                v_s2;
	logic [2*W-1:0]      v2_s2;
	logic [2*W:0]        ad_s2;
	logic [W-1:0]        amag_s2;
	logic signed [W-1:0] vel_s2;
	logic                aneg_s2, anz_s2, sub_s2, second_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		v2_s2     <= vmag_s1 * vmag_s1;
		ad_s2     <= amag_s1 * dmag_s1;
		amag_s2   <= amag_s1;
		vel_s2    <= vel_s1;
		aneg_s2   <= aneg_s1;
		anz_s2    <= anz_s1;
		sub_s2    <= sub_s1;
		second_s2 <= second_s1;
	end

	// Stage 3: discriminant v^2 + 2ad, exact and unsigned.
	logic [2*W:0] ad2_c, v2x_c, rad_c;
	logic         short_c;

	always_comb begin
		ad2_c   = {ad_s2[2*W-1:0], 1'b0};
		v2x_c   = {1'b0, v2_s2};
		short_c = sub_s2 && (ad2_c > v2x_c);
		rad_c   = sub_s2 ? (v2x_c - ad2_c) : (v2x_c + ad2_c);
	end

	logic                v_s3;
	logic [2*W:0]        rad_s3;
	logic [W-1:0]        amag_s3;
	logic signed [W-1:0] vel_s3;
	logic                aneg_s3, hit_s3, second_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		rad_s3    <= rad_c;
		amag_s3   <= amag_s2;
		vel_s3    <= vel_s2;
		aneg_s3   <= aneg_s2;
		hit_s3    <= anz_s2 && !short_c;
		second_s3 <= second_s2;
	end

	logic          sq_valid;
	logic [N-1:0]  sq_root;
	logic [SW-1:0] sq_side;

	pclt_sqrt #(.N(N), .SW(SW)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s3),
		.rad      ({1'b0, rad_s3}),
		.side     ({vel_s3, amag_s3, aneg_s3, hit_s3, second_s3}),
		.out_valid(sq_valid),
		.root     (sq_root),
		.side_out (sq_side)
	);

	// Numerator -v -+ root and the sign of the quotient.
	logic signed [W-1:0] sq_vel;
	logic [W-1:0]        sq_amag;
	logic                sq_aneg, sq_hit, sq_second;
	logic signed [W+2:0] num_c;
	logic [W+1:0]        nmag_c;

	always_comb begin
		{sq_vel, sq_amag, sq_aneg, sq_hit, sq_second} = sq_side;
		num_c  = sq_second ? ($signed({2'b00, sq_root}) - (W+3)'(sq_vel))
		                   : (-$signed({2'b00, sq_root}) - (W+3)'(sq_vel));
		nmag_c = num_c[W+2] ? (W+2)'(-num_c) : num_c[W+1:0];
	end

	logic          v_s4;
	logic [NW-1:0] num_s4;
	logic [W-1:0]  den_s4;
	logic          neg_s4, hit_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		num_s4 <= {nmag_c, {FRAC_BITS{1'b0}}};
		// A zero denominator only occurs without a hit; keep it harmless.
		den_s4 <= sq_hit ? sq_amag : W'(1);
		neg_s4 <= (num_c[W+2] != sq_aneg);
		hit_s4 <= sq_hit;
	end

	logic          dv_valid;
	logic [NW-1:0] dv_quo;
	logic [1:0]    dv_side;

	pclt_div #(.NW(NW), .DW(W), .SW(2)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s4),
		.num      (num_s4),
		.den      (den_s4),
		.side     ({neg_s4, hit_s4}),
		.out_valid(dv_valid),
		.quo      (dv_quo),
		.side_out (dv_side)
	);

	// Saturate to the signed range and apply the sign.
	logic [NW-1:0] lim_c, qs_c;
	logic [W-1:0]  t_c;

	always_comb begin
		lim_c = dv_side[1] ? (NW'(1) << (W - 1)) : ((NW'(1) << (W - 1)) - NW'(1));
		qs_c  = (dv_quo > lim_c) ? lim_c : dv_quo;
		t_c   = dv_side[1] ? W'(~qs_c + 1'b1) : qs_c[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe   <= 1'b0;
			hit      <= 1'b0;
			hit_time <= '0;
		end else begin
			strobe   <= dv_valid;
			hit      <= dv_valid && dv_side[0];
			hit_time <= (dv_valid && dv_side[0]) ? t_c : '0;
		end
	end

endmodule

// ===== hw/rtl/pclt_check.sv =====
module pclt_check #(
	parameter int unsigned DATA_WIDTH = pclt_pkg::DATA_WIDTH_DEF,
	parameter int unsigned FRAC_BITS  = pclt_pkg::FRAC_BITS_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic signed [DATA_WIDTH-1:0] start_x,
	input logic signed [DATA_WIDTH-1:0] start_y,
	input logic signed [DATA_WIDTH-1:0] speed_x,
	input logic signed [DATA_WIDTH-1:0] speed_y,
	input logic signed [DATA_WIDTH-1:0] accel_x,
	input logic signed [DATA_WIDTH-1:0] accel_y,
	input logic                         line_is_vertical,
	input logic signed [DATA_WIDTH-1:0] line_offset,
	input logic                         want_second,
	input logic                         strobe,
	input logic                         hit,
	input logic signed [DATA_WIDTH-1:0] hit_time
);
	import pclt_pkg::*;

	localparam int unsigned LAT = pclt_latency(DATA_WIDTH, FRAC_BITS);
	localparam int unsigned CW  = $clog2(LAT + 1);

	// Cycles since reset, held once the pipeline history is all post-reset.
	logic [CW-1:0] warm_q;
	logic          zacc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_q <= '0;
		end else if (warm_q != CW'(LAT)) begin
			warm_q <= warm_q + 1'b1;
		end
	end

	assign zacc = line_is_vertical ? (accel_x == '0) : (accel_y == '0);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(warm_q == CW'(LAT)) |-> (strobe == $past(start && !busy, LAT)))
		else $error("result strobe does not follow the accepted item");

	a_zero_accel: assert property (@(posedge clk) disable iff (!arst_n)
		((warm_q == CW'(LAT)) && $past(start && !busy && zacc, LAT)) |-> !hit)
		else $error("hit reported for zero acceleration");

	a_nohit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !hit) |-> (hit_time == '0))
		else $error("time not zero without a hit");

	a_hit_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		hit |-> strobe)
		else $error("hit outside a result cycle");

endmodule

bind parabola_line_crossing_time pclt_check #(
	.DATA_WIDTH(DATA_WIDTH),
	.FRAC_BITS (FRAC_BITS)
) u_pclt_check (.*);
